### hdl/pcpt_pkg.sv
// Shared types and constants for the point-in-convex-polygon test unit.
// No dependencies; used by every other file of the block.
`default_nettype none

package pcpt_pkg;

    // Command codes carried on the cmd field.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // Fixed field widths.
    localparam int IDXW = 6;
    localparam int CNTW = 7;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_WRAP,
        ST_FIN
    } t_state;

    // Controls for the row of vertex cells.
    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

    // Tag that travels with an edge through the edge unit.
    typedef struct packed {
        logic valid;
        logic wrap;
    } t_edge_tag;

    // Outcome of one edge.
    typedef struct packed {
        logic valid;
        logic wrap;
        logic straddle;
        logic hit;
    } t_edge_res;

endpackage

`default_nettype wire

### hdl/pcpt_cell.sv
// One vertex cell: stores one polygon vertex and one stage of the read chain.
// Depends on pcpt_pkg for the chain control struct.
`default_nettype none

module pcpt_cell #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_wen,
    input  wire logic signed [COORD_WIDTH-1:0] i_wx,
    input  wire logic signed [COORD_WIDTH-1:0] i_wy,
    input  wire pcpt_pkg::t_chain_ctl    i_ctl,
    input  wire logic signed [COORD_WIDTH-1:0] i_nx,
    input  wire logic signed [COORD_WIDTH-1:0] i_ny,
    output logic signed [COORD_WIDTH-1:0]      o_sx,
    output logic signed [COORD_WIDTH-1:0]      o_sy
);

    logic signed [COORD_WIDTH-1:0] r_vx;
    logic signed [COORD_WIDTH-1:0] r_vy;
    logic signed [COORD_WIDTH-1:0] r_sx;
    logic signed [COORD_WIDTH-1:0] r_sy;

    // Stored vertex, written by a vertex load aimed at this slot.
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_vx <= i_wx;
            r_vy <= i_wy;
        end
    end

    // Chain stage: loads the stored vertex, then takes the neighbor's value.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sx <= r_vx;
            r_sy <= r_vy;
        end else if (i_ctl.shift) begin
            r_sx <= i_nx;
            r_sy <= i_ny;
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;

endmodule

`default_nettype wire

### hdl/pcpt_edge.sv
// Edge unit: decides whether one polygon edge straddles the test point's Y
// and whether the +X ray hits it. Two stages; depends on pcpt_pkg.
`default_nettype none

module pcpt_edge #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire pcpt_pkg::t_edge_tag            i_tag,
    input  wire logic signed [COORD_WIDTH-1:0]  i_x0,
    input  wire logic signed [COORD_WIDTH-1:0]  i_y0,
    input  wire logic signed [COORD_WIDTH-1:0]  i_x1,
    input  wire logic signed [COORD_WIDTH-1:0]  i_y1,
    input  wire logic signed [COORD_WIDTH-1:0]  i_tx,
    input  wire logic signed [COORD_WIDTH-1:0]  i_ty,
    output pcpt_pkg::t_edge_res                 o_res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [DW-1:0] c_dy;
    logic signed [DW-1:0] c_dx;
    logic signed [DW-1:0] c_ax;
    logic signed [DW-1:0] c_by;
    logic signed [PW-1:0] c_l;
    logic signed [PW-1:0] c_r;
    logic                 c_xf0;
    logic                 c_xf1;

    pcpt_pkg::t_edge_tag  r_tag;
    logic                 r_straddle;
    logic                 r_xsame;
    logic                 r_xf0;
    logic                 r_dypos;
    logic signed [PW-1:0] r_l;
    logic signed [PW-1:0] r_r;
    logic                 c_cross;

    // First stage: differences, the two cross products and the quick flags.
    always_comb begin
        c_dy  = $signed({i_y0[COORD_WIDTH-1], i_y0}) - $signed({i_y1[COORD_WIDTH-1], i_y1});
        c_dx  = $signed({i_x0[COORD_WIDTH-1], i_x0}) - $signed({i_x1[COORD_WIDTH-1], i_x1});
        c_ax  = $signed({i_x1[COORD_WIDTH-1], i_x1}) - $signed({i_tx[COORD_WIDTH-1], i_tx});
        c_by  = $signed({i_y1[COORD_WIDTH-1], i_y1}) - $signed({i_ty[COORD_WIDTH-1], i_ty});
        c_l   = PW'(c_ax) * PW'(c_dy);
        c_r   = PW'(c_by) * PW'(c_dx);
        c_xf0 = (i_x0 >= i_tx);
        c_xf1 = (i_x1 >= i_tx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_straddle <= ((i_y0 >= i_ty) != (i_y1 >= i_ty));
        r_xsame    <= (c_xf0 == c_xf1);
        r_xf0      <= c_xf0;
        r_dypos    <= (i_y0 > i_y1);
        r_l        <= c_l;
        r_r        <= c_r;
    end

    // Second stage: the exact intersection compare, reversed when dy is not positive.
    always_comb begin
        c_cross        = r_dypos ? (r_l >= r_r) : (r_r >= r_l);
        o_res.valid    = r_tag.valid;
        o_res.wrap     = r_tag.wrap;
        o_res.straddle = r_straddle;
        o_res.hit      = r_xsame ? r_xf0 : c_cross;
    end

endmodule

`default_nettype wire

### hdl/point_in_convex_polygon_test_unit.sv
// Top level of the point-in-convex-polygon test unit: vertex cell row,
// walk sequencer and edge unit. Depends on pcpt_pkg, pcpt_cell, pcpt_edge.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+----------------------------------------
//  command  | start / busy            | i_cmd, i_vertex_index, i_x_coord, i_y_coord
//  result   | o_res_valid (strobe)    | o_inside_res
//  config   | i_cfg_we                | i_cfg_wdata (vertex_count)
//
// A vertex load gives no result. For a point test, the vertex row shifts
// one vertex per cycle to cell 0, then the closing edge passes the
// two-stage edge unit before the result strobe. A test with no vertices
// answers next cycle.
// Reset is synchronous and active low; vertex_count returns to 3.
// The result is shown for one cycle and cannot be held off.
`default_nettype none

module point_in_convex_polygon_test_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_cmd,
    input  wire [pcpt_pkg::IDXW-1:0]           i_vertex_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  wire                                i_cfg_we,
    input  wire [pcpt_pkg::CNTW-1:0]           i_cfg_wdata,
    output logic                               o_res_valid,
    output logic                               o_inside_res
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int JW = $clog2(MAX_VERTICES);
    localparam int SW = (CW > pcpt_pkg::CNTW) ? CW : pcpt_pkg::CNTW;

    pcpt_pkg::t_state     r_state;
    pcpt_pkg::t_state     n_state;
    pcpt_pkg::t_chain_ctl c_ctl;
    pcpt_pkg::t_edge_tag  c_tag;
    pcpt_pkg::t_edge_res  w_res;

    logic [pcpt_pkg::CNTW-1:0] r_vertex_count;
    logic [CW-1:0]             r_n;
    logic [SW-1:0]             c_cnt_ext;
    logic [CW-1:0]             c_n;
    logic [JW-1:0]             r_j;
    logic                      c_last;

    logic signed [COORD_WIDTH-1:0] r_tx;
    logic signed [COORD_WIDTH-1:0] r_ty;
    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;
    logic signed [COORD_WIDTH-1:0] r_v0x;
    logic signed [COORD_WIDTH-1:0] r_v0y;
    logic signed [COORD_WIDTH-1:0] c_cx;
    logic signed [COORD_WIDTH-1:0] c_cy;

    logic signed [COORD_WIDTH-1:0] w_sx [MAX_VERTICES+1];
    logic signed [COORD_WIDTH-1:0] w_sy [MAX_VERTICES+1];

    logic       c_acc;
    logic       c_wr;
    logic       c_test;
    logic       c_empty;
    logic [1:0] r_found;
    logic       r_h1;
    logic       r_h12;
    logic       r_res_valid;
    logic       r_inside;
    logic       n_res_valid;
    logic       n_inside;

    // Command transfer decode.
    assign busy    = (r_state != pcpt_pkg::ST_IDLE);
    assign c_acc   = start && !busy;
    assign c_wr    = c_acc && (i_cmd == pcpt_pkg::CMD_WRITE);
    assign c_test  = c_acc && (i_cmd == pcpt_pkg::CMD_TEST);

    // Vertex count in use, saturated to the table depth.
    always_comb begin
        c_cnt_ext = SW'(r_vertex_count);
        c_n       = (c_cnt_ext > SW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(c_cnt_ext);
        c_empty   = (c_n == '0);
        c_last    = (CW'(r_j) == (r_n - CW'(1)));
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= pcpt_pkg::CNTW'(3);
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // Row of vertex cells; cell 0 presents the vertex being walked.
    assign w_sx[MAX_VERTICES] = '0;
    assign w_sy[MAX_VERTICES] = '0;

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        logic c_wen;
        assign c_wen = c_wr && (k < (1 << pcpt_pkg::IDXW)) &&
                       (i_vertex_index == pcpt_pkg::IDXW'(k));

        pcpt_cell #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .i_clk (i_clk),
            .i_wen (c_wen),
            .i_wx  (i_x_coord),
            .i_wy  (i_y_coord),
            .i_ctl (c_ctl),
            .i_nx  (w_sx[k+1]),
            .i_ny  (w_sy[k+1]),
            .o_sx  (w_sx[k]),
            .o_sy  (w_sy[k])
        );
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, chain controls and edge issue. The walk covers edges
    // (0,1) .. (n-2,n-1); the closing edge (n-1,0) goes last.
    always_comb begin
        n_state = r_state;
        c_ctl   = '0;
        c_tag   = '0;
        case (r_state)
            pcpt_pkg::ST_IDLE: begin
                if (c_test && !c_empty) begin
                    c_ctl.load = 1'b1;
                    n_state    = pcpt_pkg::ST_WALK;
                end
            end
            pcpt_pkg::ST_WALK: begin
                c_ctl.shift = 1'b1;
                c_tag.valid = (r_j != '0);
                if (c_last) begin
                    n_state = pcpt_pkg::ST_WRAP;
                end
            end
            pcpt_pkg::ST_WRAP: begin
                c_tag.valid = 1'b1;
                c_tag.wrap  = 1'b1;
                n_state     = pcpt_pkg::ST_FIN;
            end
            pcpt_pkg::ST_FIN: begin
                n_state = pcpt_pkg::ST_IDLE;
            end
            default: begin
                n_state = pcpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Walk counter, test point and previous / first vertex.
    always_ff @(posedge i_clk) begin
        if (c_test) begin
            r_tx <= i_x_coord;
            r_ty <= i_y_coord;
            r_n  <= c_n;
            r_j  <= '0;
        end else if (r_state == pcpt_pkg::ST_WALK) begin
            r_j <= r_j + JW'(1);
        end
        if (r_state == pcpt_pkg::ST_WALK) begin
            r_px <= w_sx[0];
            r_py <= w_sy[0];
            if (r_j == '0) begin
                r_v0x <= w_sx[0];
                r_v0y <= w_sy[0];
            end
        end
    end

    // The closing edge ends at vertex 0, saved at the start of the walk.
    assign c_cx = (r_state == pcpt_pkg::ST_WRAP) ? r_v0x : w_sx[0];
    assign c_cy = (r_state == pcpt_pkg::ST_WRAP) ? r_v0y : w_sy[0];

    pcpt_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (c_tag),
        .i_x0    (r_px),
        .i_y0    (r_py),
        .i_x1    (c_cx),
        .i_y1    (c_cy),
        .i_tx    (r_tx),
        .i_ty    (r_ty),
        .o_res   (w_res)
    );

    // Parity of the first one and first two straddling edges of the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || c_test) begin
            r_found <= '0;
            r_h1    <= 1'b0;
            r_h12   <= 1'b0;
        end else if (w_res.valid && !w_res.wrap && w_res.straddle) begin
            if (r_found == 2'd0) begin
                r_h1    <= w_res.hit;
                r_h12   <= w_res.hit;
                r_found <= 2'd1;
            end else if (r_found == 2'd1) begin
                r_h12   <= r_h12 ^ w_res.hit;
                r_found <= 2'd2;
            end
        end
    end

    // Result: a straddling closing edge is the first one, so it pairs with
    // the first straddling edge of the walk; otherwise the first two count. A test with no vertices answers outside.
    always_comb begin
        n_res_valid = (c_test && c_empty) || (w_res.valid && w_res.wrap);
        if (c_test && c_empty) begin
            n_inside = 1'b0;
        end else if (w_res.straddle) begin
            n_inside = w_res.hit ^ r_h1;
        end else begin
            n_inside = r_h12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            r_inside <= n_inside;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_inside_res = r_inside;

endmodule

`default_nettype wire

### hdl/pcpt_checker.sv
// Port-level checks for the point-in-convex-polygon test unit, bound to the
// top level. Depends on pcpt_pkg and point_in_convex_polygon_test_unit.
`default_nettype none

module pcpt_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_start,
    input wire i_busy,
    input wire i_cmd,
    input wire i_res_valid
);

    // A result strobe never overlaps a running test.
    a_res_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_busy)
        else $error("result strobe while busy");

    // A vertex load transfer produces no result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && (i_cmd == pcpt_pkg::CMD_WRITE)) |=> !i_res_valid)
        else $error("result after a vertex load");

    // A test transfer either starts a walk or answers at once.
    a_test_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && (i_cmd == pcpt_pkg::CMD_TEST)) |=> (i_busy || i_res_valid))
        else $error("test transfer neither started nor answered");

    // Every walk ends with its result.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_busy) |-> i_res_valid)
        else $error("walk ended without a result");

endmodule

bind point_in_convex_polygon_test_unit pcpt_checker u_pcpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (start),
    .i_busy      (busy),
    .i_cmd       (i_cmd),
    .i_res_valid (o_res_valid)
);

`default_nettype wire

### sim/point_in_convex_polygon_test_unit_checker.sv
// Checker for the point-in-convex-polygon test unit: follows command, configuration
// and result transfers, predicts each inside bit and compares it with the block's answer.
// Depends on pcpt_pkg.
`default_nettype none

module point_in_convex_polygon_test_unit_checker #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire                                i_busy,
    input  wire                                i_cmd,
    input  wire [pcpt_pkg::IDXW-1:0]           i_vertex_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  wire                                i_cfg_we,
    input  wire [pcpt_pkg::CNTW-1:0]           i_cfg_wdata,
    input  wire                                i_res_valid,
    input  wire                                i_inside_res,
    output int                                 o_mismatches,
    output int                                 o_pending
);

    // Shadow copy of the vertex table and the vertex count register.
    logic signed [COORD_WIDTH-1:0] vert_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vert_y [MAX_VERTICES];
    logic [pcpt_pkg::CNTW-1:0]     vertex_count;

    // Inside bits predicted for tests that have been accepted but not answered.
    logic inside_expected_q [$];

    // Crossing-parity walk over the edges, starting with the closing edge. The walk
    // stops once an edge straddles the point's Y after an earlier edge already did.
    function automatic logic predict_inside(input longint px, input longint py);
        int     n;
        int     prev;
        logic   parity;
        logic   crossed_once;
        logic   finished;
        logic   above_prev;
        logic   above_cur;
        logic   right_prev;
        longint x0, y0, x1, y1, dy, lhs, rhs;
        n = (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        if (n == 0) begin
            return 1'b0;
        end
        parity       = 1'b0;
        crossed_once = 1'b0;
        finished     = 1'b0;
        prev         = n - 1;
        above_prev   = longint'(vert_y[prev]) >= py;
        for (int i = 0; i < n && !finished; i++) begin
            x0 = longint'(vert_x[prev]);
            y0 = longint'(vert_y[prev]);
            x1 = longint'(vert_x[i]);
            y1 = longint'(vert_y[i]);
            above_cur = y1 >= py;
            if (above_prev != above_cur) begin
                right_prev = x0 >= px;
                if (right_prev == (x1 >= px)) begin
                    // Both ends on one side of the point: only the right side counts.
                    if (right_prev) begin
                        parity = ~parity;
                    end
                end else begin
                    // Exact intersection test, scaled by dy with its sign respected.
                    dy  = y0 - y1;
                    lhs = (x1 - px) * dy;
                    rhs = (y1 - py) * (x0 - x1);
                    if (dy > 0 ? (lhs >= rhs) : (rhs >= lhs)) begin
                        parity = ~parity;
                    end
                end
                if (crossed_once) begin
                    finished = 1'b1;
                end
                crossed_once = 1'b1;
            end
            above_prev = above_cur;
            prev       = i;
        end
        return parity;
    endfunction

    // All transfers are sampled at the rising edge; results are checked before a
    // command of the same edge is predicted.
    always @(posedge i_clk) begin : watch
        logic want;
        if (!i_rst_n) begin
            vertex_count = pcpt_pkg::CNTW'(3);
            inside_expected_q.delete();
            o_mismatches = 0;
            o_pending    = 0;
        end else begin
            // Result transfer: compare with the oldest prediction.
            if (i_res_valid) begin
                if (inside_expected_q.size() == 0) begin
                    $error("inside_res: expected no result, actual %0b", i_inside_res);
                    o_mismatches++;
                end else begin
                    want = inside_expected_q.pop_front();
                    if (i_inside_res !== want) begin
                        $error("inside_res: expected %0b, actual %0b", want, i_inside_res);
                        o_mismatches++;
                    end
                end
            end

            // Command transfer: store a vertex or predict a test with the count
            // that held before this edge.
            if (i_start && !i_busy) begin
                if (i_cmd == pcpt_pkg::CMD_WRITE) begin
                    if (int'(i_vertex_index) < MAX_VERTICES) begin
                        vert_x[i_vertex_index] = i_x_coord;
                        vert_y[i_vertex_index] = i_y_coord;
                    end
                end else begin
                    inside_expected_q.push_back(predict_inside(i_x_coord, i_y_coord));
                end
            end

            // Register write.
            if (i_cfg_we) begin
                vertex_count = i_cfg_wdata;
            end
            o_pending = inside_expected_q.size();
        end
    end

endmodule

`default_nettype wire

### sim/point_in_convex_polygon_test_unit_tb.sv
// Testbench top for the point-in-convex-polygon test unit: drives vertex loads, point
// tests and vertex count writes, and gives the verdict from the checker's counts.
// Depends on pcpt_pkg, point_in_convex_polygon_test_unit and its checker.
`default_nettype none

module point_in_convex_polygon_test_unit_tb;

    localparam int MAX_VERTICES  = 64;
    localparam int COORD_WIDTH   = 16;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int COORD_MIN     = -32768;
    localparam int COORD_MAX     = 32767;

    // Block inputs, all known from time zero.
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          start          = 1'b0;
    logic                          i_cmd          = pcpt_pkg::CMD_WRITE;
    logic [pcpt_pkg::IDXW-1:0]     i_vertex_index = '0;
    logic signed [COORD_WIDTH-1:0] i_x_coord      = '0;
    logic signed [COORD_WIDTH-1:0] i_y_coord      = '0;
    logic                          i_cfg_we       = 1'b0;
    logic [pcpt_pkg::CNTW-1:0]     i_cfg_wdata    = '0;

    wire busy;
    wire o_res_valid;
    wire o_inside_res;
    int  mismatches;
    int  pending;

    // Stimulus bookkeeping.
    int          gap_mode    = 0;
    int          items_sent  = 0;
    int unsigned cycle_count = 0;

    // Intended polygon of the current phase, used to aim test points.
    int poly_x [MAX_VERTICES];
    int poly_y [MAX_VERTICES];
    int poly_n = 0;
    int min_x, max_x, min_y, max_y;

    always #4 i_clk = ~i_clk;

    point_in_convex_polygon_test_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_vertex_index(i_vertex_index),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_res_valid   (o_res_valid),
        .o_inside_res  (o_inside_res)
    );

    point_in_convex_polygon_test_unit_checker #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_vertex_index(i_vertex_index),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_res_valid   (o_res_valid),
        .i_inside_res  (o_inside_res),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    function automatic int clip_coord(input int v);
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        return v;
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Idle cycles ahead of the next command, by the phase's idling mode.
    function automatic int draw_gap();
        case (gap_mode)
            0: return 0;
            1: return int'($urandom_range(0, 15));
            default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 15)) : 0;
        endcase
    endfunction

    // One command transfer. Start stays high after the transfer so that a
    // back-to-back command needs no second assignment in the same step.
    task automatic send_command(input logic cmd, input int slot, input int px, input int py);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_vertex_index <= pcpt_pkg::IDXW'(slot);
        i_x_coord      <= COORD_WIDTH'(px);
        i_y_coord      <= COORD_WIDTH'(py);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_vertex(input int slot, input int vx, input int vy);
        send_command(pcpt_pkg::CMD_WRITE, slot, vx, vy);
    endtask

    task automatic test_point(input int px, input int py);
        send_command(pcpt_pkg::CMD_TEST, int'($urandom_range(0, 63)), px, py);
    endtask

    // Drop start, wait for every predicted result and for the block to go quiet.
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pcpt_pkg::CNTW'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Roughly regular polygon around a random center; rounding and clipping to the coordinate range may bend it.
    task automatic build_polygon(input int n);
        real cx, cy, radius, step, turn, ang;
        int  dir;
        cx = real'(rand_between(COORD_MIN, COORD_MAX));
        cy = real'(rand_between(COORD_MIN, COORD_MAX));
        case ($urandom_range(0, 3))
            0: radius = real'(rand_between(1, 40));
            1: radius = real'(rand_between(40, 2000));
            2: radius = real'(rand_between(2000, 20000));
            default: radius = real'(rand_between(20000, 46000));
        endcase
        step = 2.0 * 3.14159265358979 / real'(n);
        turn = real'($urandom_range(0, 6283)) / 1000.0;
        dir  = ($urandom_range(0, 1) == 1) ? 1 : -1;
        poly_n = n;
        min_x = COORD_MAX;
        max_x = COORD_MIN;
        min_y = COORD_MAX;
        max_y = COORD_MIN;
        for (int k = 0; k < n; k++) begin
            ang = turn + real'(dir) * (real'(k) + real'($urandom_range(0, 800)) / 1000.0) * step;
            poly_x[k] = clip_coord($rtoi(cx + radius * $cos(ang)));
            poly_y[k] = clip_coord($rtoi(cy + radius * $sin(ang)));
            if (poly_x[k] < min_x) min_x = poly_x[k];
            if (poly_x[k] > max_x) max_x = poly_x[k];
            if (poly_y[k] < min_y) min_y = poly_y[k];
            if (poly_y[k] > max_y) max_y = poly_y[k];
        end
    endtask

    // Test point aimed at the polygon: vertices, shared Y values, edge midpoints,
    // the widened bounding box, and now and then anywhere at all.
    task automatic pick_point(output int px, output int py);
        int k, j, mx, my;
        if (poly_n == 0 || $urandom_range(0, 9) == 0) begin
            px = rand_between(COORD_MIN, COORD_MAX);
            py = rand_between(COORD_MIN, COORD_MAX);
            return;
        end
        k = rand_between(0, poly_n - 1);
        j = (k + 1) % poly_n;
        mx = (max_x - min_x) / 8 + 1;
        my = (max_y - min_y) / 8 + 1;
        case ($urandom_range(0, 8))
            0: begin
                px = poly_x[k];
                py = poly_y[k];
            end
            1: begin
                px = rand_between(clip_coord(min_x - mx), clip_coord(max_x + mx));
                py = poly_y[k];
            end
            2: begin
                px = (poly_x[k] + poly_x[j]) / 2;
                py = (poly_y[k] + poly_y[j]) / 2;
            end
            default: begin
                px = rand_between(clip_coord(min_x - mx), clip_coord(max_x + mx));
                py = rand_between(clip_coord(min_y - my), clip_coord(max_y + my));
            end
        endcase
    endtask

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int count, n_eff, tests, first_random, px, py;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a triangle spanning the full coordinate range, tested with
        // the reset vertex count.
        load_vertex(0, COORD_MIN, COORD_MIN);
        load_vertex(1, COORD_MAX, COORD_MIN);
        load_vertex(2, 0, COORD_MAX);
        test_point(0, 0);
        test_point(COORD_MIN, COORD_MIN);
        test_point(COORD_MAX, COORD_MAX);
        test_point(COORD_MIN, COORD_MAX);
        test_point(COORD_MAX, COORD_MIN);
        test_point(0, COORD_MIN);
        test_point(0, COORD_MAX);
        test_point(-1, 1);
        // A test ignores vertex_index; drive it to the top slot explicitly.
        send_command(pcpt_pkg::CMD_TEST, 63, 1, -1);

        // No vertices in use: the answer is always outside.
        set_vertex_count(0);
        test_point(0, 0);
        // One vertex: no edge can straddle.
        set_vertex_count(1);
        test_point(0, 0);
        test_point(COORD_MIN, 0);
        // Two vertices: the walk runs over a degenerate polygon.
        set_vertex_count(2);
        test_point(0, COORD_MIN);
        test_point(0, 0);
        test_point(COORD_MAX, COORD_MIN);

        // Random phases: vertex count, full polygon load, then tests with some noise.
        first_random = items_sent;
        for (int phase = 0; items_sent - first_random < RANDOM_ITEMS; phase++) begin
            if (phase == 0) begin
                count = 127;
            end else if (phase == 1) begin
                count = 64;
            end else begin
                case ($urandom_range(0, 19))
                    0: count = 0;
                    1: count = 1;
                    2: count = 2;
                    3: count = 64;
                    4: count = rand_between(65, 127);
                    5: count = rand_between(13, 63);
                    default: count = rand_between(3, 12);
                endcase
            end
            set_vertex_count(count);
            gap_mode = int'($urandom_range(0, 2));
            n_eff = (count > MAX_VERTICES) ? MAX_VERTICES : count;
            poly_n = 0;
            if (n_eff > 0) begin
                build_polygon(n_eff);
                if ($urandom_range(0, 1) == 1) begin
                    for (int k = 0; k < n_eff; k++) load_vertex(k, poly_x[k], poly_y[k]);
                end else begin
                    for (int k = n_eff - 1; k >= 0; k--) load_vertex(k, poly_x[k], poly_y[k]);
                end
            end
            tests = (n_eff == 0) ? 4 : rand_between(8, 30);
            repeat (tests) begin
                // Noise: a stray vertex write, which may bend the loaded polygon.
                if ($urandom_range(0, 9) == 0) begin
                    load_vertex(rand_between(0, 63), rand_between(COORD_MIN, COORD_MAX),
                                rand_between(COORD_MIN, COORD_MAX));
                end
                pick_point(px, py);
                test_point(px, py);
            end
        end

        wait_idle();
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
